FILE: sv/pfe_pkg.sv
// Package for the page framebuffer ellipse engine: screen constants, command
// codes and the sequencer state type. No dependencies.
package pfe_pkg;
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
  localparam int AW            = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_PIXEL   = 3'd1,
    KIND_LINE    = 3'd2,
    KIND_ELLIPSE = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_PIX_RD, ST_PIX_WR, ST_LINE_RD, ST_LINE_WR,
    ST_EL_SETUP, ST_EL_TEST, ST_EL_RD, ST_EL_WR, ST_EL_UPD, ST_EL_R2INIT,
    ST_READ, ST_OUT
  } state_t;
endpackage

FILE: sv/page_framebuffer_ellipse_engine.sv
// Page framebuffer with pixel, horizontal line and midpoint ellipse drawing.
// Depends on pfe_pkg; holds the frame store as one memory with a read port and a write port.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_kind .. in_address
//  out     | output    | out_valid, out_stall, out_read_data, out_done_kind
//
// One command at a time. Every plotted pixel is a read-modify-write of the store;
// a line does one per column, an ellipse step runs the loop test, the four
// symmetric points and the decision update, after a setup and with a fresh
// start at the region change; clear zeroes all 1024 bytes of the store.
// After reset a clearing pass over all STORE_BYTES bytes runs before in_stall drops.
// The result waits in an output register; a finished command keeps in_stall
// high while that register is still full and out_stall is high.
module page_framebuffer_ellipse_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [8:0] in_pos_y,
  input  logic signed [8:0] in_end_x,
  input  logic [7:0]        in_radius_x,
  input  logic [7:0]        in_radius_y,
  input  logic              in_color,
  input  logic [9:0]        in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_data,
  output logic [2:0]        out_done_kind
);
  localparam int AW = pfe_pkg::AW;

  logic [7:0] mem [pfe_pkg::STORE_BYTES];
  logic [7:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  pfe_pkg::state_t state_r, state_nxt;
  logic [2:0] kind_r;
  logic signed [10:0] cx_r, cy_r, lx_r, ex_r;
  logic color_r;
  logic [9:0] raddr_r;
  logic [AW-1:0] cnt_r;
  logic [7:0] res_r;
  logic [2:0] out_kind_r;
  logic out_valid_r;
  // ellipse
  logic signed [17:0] rx2_r, ry2_r;
  logic signed [9:0] ex_step_r, ey_step_r;
  logic signed [39:0] d_r;
  logic region_two_r;
  logic [1:0] quad_r;
  logic [7:0] rx_r, ry_r;
  logic signed [39:0] t1_r, t2_r;  // registered products
  logic [2:0] sub_r;

  // pixel coordinate for the current plot
  logic signed [11:0] px, py;
  logic on_screen;
  logic [AW-1:0] pix_addr;
  logic [7:0] pix_mask;

  always_comb begin
    px = {cx_r[10], cx_r};
    py = {cy_r[10], cy_r};
    case (state_r)
      pfe_pkg::ST_LINE_RD, pfe_pkg::ST_LINE_WR: begin
        px = {lx_r[10], lx_r};
      end
      pfe_pkg::ST_EL_RD, pfe_pkg::ST_EL_WR: begin
        px = quad_r[0] ? {cx_r[10], cx_r} - {{2{ex_step_r[9]}}, ex_step_r}
                       : {cx_r[10], cx_r} + {{2{ex_step_r[9]}}, ex_step_r};
        py = quad_r[1] ? {cy_r[10], cy_r} - {{2{ey_step_r[9]}}, ey_step_r}
                       : {cy_r[10], cy_r} + {{2{ey_step_r[9]}}, ey_step_r};
      end
      default: ;
    endcase
    on_screen = (px >= 0) && (px < pfe_pkg::SCREEN_WIDTH) &&
                (py >= 0) && (py < pfe_pkg::SCREEN_HEIGHT);
    pix_addr = AW'(32'(py[11:3]) * pfe_pkg::SCREEN_WIDTH + 32'(px[8:0]));
    pix_mask = 8'(1) << py[2:0];
  end

  // ellipse loop conditions
  logic signed [39:0] exs, eys;
  logic r1_cont, r2_cont;
  always_comb begin
    exs = 40'(ex_step_r);
    eys = 40'(ey_step_r);
    r1_cont = (t1_r <= t2_r);  // ry2*x <= rx2*y
    r2_cont = (ey_step_r >= 0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfe_pkg::ST_INIT:  if (cnt_r == AW'(pfe_pkg::STORE_BYTES - 1)) state_nxt = pfe_pkg::ST_IDLE;
      pfe_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            pfe_pkg::KIND_CLEAR:   state_nxt = pfe_pkg::ST_CLEAR;
            pfe_pkg::KIND_PIXEL:   state_nxt = pfe_pkg::ST_PIX_RD;
            pfe_pkg::KIND_LINE:    state_nxt = pfe_pkg::ST_LINE_RD;
            pfe_pkg::KIND_ELLIPSE: state_nxt = pfe_pkg::ST_EL_SETUP;
            pfe_pkg::KIND_READ:    state_nxt = pfe_pkg::ST_READ;
            default:               state_nxt = pfe_pkg::ST_OUT;
          endcase
        end
      end
      pfe_pkg::ST_CLEAR: if (cnt_r == AW'(pfe_pkg::STORE_BYTES - 1)) state_nxt = pfe_pkg::ST_OUT;
      pfe_pkg::ST_PIX_RD: state_nxt = pfe_pkg::ST_PIX_WR;
      pfe_pkg::ST_PIX_WR: state_nxt = pfe_pkg::ST_OUT;
      pfe_pkg::ST_LINE_RD: state_nxt = (lx_r > ex_r) ? pfe_pkg::ST_OUT : pfe_pkg::ST_LINE_WR;
      pfe_pkg::ST_LINE_WR: state_nxt = pfe_pkg::ST_LINE_RD;
      pfe_pkg::ST_EL_SETUP: if (sub_r == 3'd3) state_nxt =
        (rx_r == 8'd0 && ry_r == 8'd0) ? pfe_pkg::ST_PIX_RD : pfe_pkg::ST_EL_TEST;
      pfe_pkg::ST_EL_TEST: begin
        if (sub_r == 3'd1) begin
          if (!region_two_r) state_nxt = r1_cont ? pfe_pkg::ST_EL_RD : pfe_pkg::ST_EL_R2INIT;
          else state_nxt = r2_cont ? pfe_pkg::ST_EL_RD : pfe_pkg::ST_OUT;
        end
      end
      pfe_pkg::ST_EL_RD: state_nxt = pfe_pkg::ST_EL_WR;
      pfe_pkg::ST_EL_WR: state_nxt = (quad_r == 2'd3) ? pfe_pkg::ST_EL_UPD : pfe_pkg::ST_EL_RD;
      pfe_pkg::ST_EL_UPD: if (sub_r == 3'd2) state_nxt = pfe_pkg::ST_EL_TEST;
      pfe_pkg::ST_EL_R2INIT: if (sub_r == 3'd3) state_nxt = pfe_pkg::ST_EL_TEST;
      pfe_pkg::ST_READ: state_nxt = pfe_pkg::ST_OUT;
      pfe_pkg::ST_OUT: if (!out_valid_r || !out_stall) state_nxt = pfe_pkg::ST_IDLE;
      default: state_nxt = pfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != pfe_pkg::ST_IDLE);
    wr_en = 1'b0;
    wr_addr = pix_addr;
    wr_data = rd_data_r | pix_mask;
    rd_addr = pix_addr;
    case (state_r)
      pfe_pkg::ST_INIT, pfe_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = cnt_r;
        wr_data = 8'd0;
      end
      pfe_pkg::ST_PIX_WR: begin
        wr_en = on_screen;
        wr_data = color_r ? (rd_data_r | pix_mask) : (rd_data_r & ~pix_mask);
      end
      pfe_pkg::ST_LINE_WR, pfe_pkg::ST_EL_WR: wr_en = on_screen;
      // keep the read byte while the result waits
      pfe_pkg::ST_READ, pfe_pkg::ST_OUT: rd_addr = raddr_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfe_pkg::ST_INIT;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      res_r <= 8'd0;
      out_kind_r <= 3'd0;
      region_two_r <= 1'b0;
      d_r <= '0;
      ex_step_r <= '0;
      ey_step_r <= '0;
      sub_r <= '0;
      quad_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfe_pkg::ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        out_kind_r <= kind_r;
        res_r <= (kind_r == pfe_pkg::KIND_READ && 32'(raddr_r) < pfe_pkg::STORE_BYTES)
                 ? rd_data_r : 8'd0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        pfe_pkg::ST_INIT, pfe_pkg::ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        pfe_pkg::ST_IDLE: begin
          cnt_r <= '0;
          sub_r <= '0;
          quad_r <= '0;
          if (in_valid) begin
            kind_r <= in_kind;
            cx_r <= 11'(in_pos_x);
            cy_r <= 11'(in_pos_y);
            lx_r <= 11'(in_pos_x);
            ex_r <= 11'(in_end_x);
            color_r <= (in_kind == pfe_pkg::KIND_ELLIPSE) ? 1'b1 : in_color;
            raddr_r <= in_address;
            rx_r <= in_radius_x;
            ry_r <= in_radius_y;
          end
        end
        pfe_pkg::ST_LINE_WR: lx_r <= lx_r + 1'b1;
        pfe_pkg::ST_EL_SETUP: begin
          if (sub_r == 3'd3) sub_r <= '0;
          else sub_r <= sub_r + 1'b1;
          region_two_r <= 1'b0;
          case (sub_r)
            3'd0: begin
              rx2_r <= 18'(rx_r) * 18'(rx_r);
              ry2_r <= 18'(ry_r) * 18'(ry_r);
              ex_step_r <= '0;
              ey_step_r <= 10'(ry_r);
            end
            3'd1: t1_r <= 40'(rx2_r) * 40'(ry_r);
            3'd2: begin
              if (rx_r == 8'd0 && ry_r == 8'd0) begin
                d_r <= '0;
                ey_step_r <= '0;
              end else begin
                d_r <= 4 * 40'(ry2_r) - 4 * t1_r + 40'(rx2_r);
              end
            end
            default: ;
          endcase
        end
        pfe_pkg::ST_EL_TEST: begin
          if (sub_r == 3'd0) begin
            sub_r <= 3'd1;
            t1_r <= 40'(ry2_r) * exs;
            t2_r <= 40'(rx2_r) * eys;
          end else begin
            sub_r <= '0;
          end
        end
        pfe_pkg::ST_EL_WR: quad_r <= quad_r + 1'b1;
        pfe_pkg::ST_EL_UPD: begin
          // x/y step first, then products of new values, then add
          if (sub_r == 3'd2) sub_r <= '0;
          else sub_r <= sub_r + 1'b1;
          case (sub_r)
            3'd0: begin
              if (!region_two_r) begin
                ex_step_r <= ex_step_r + 1'b1;
                if (d_r >= 0) ey_step_r <= ey_step_r - 1'b1;
              end else begin
                ey_step_r <= ey_step_r - 1'b1;
                if (d_r <= 0) ex_step_r <= ex_step_r + 1'b1;
              end
            end
            3'd1: begin
              t1_r <= 40'(ry2_r) * exs;
              t2_r <= 40'(rx2_r) * eys;
            end
            default: begin
              if (!region_two_r) begin
                if (d_r < 0) d_r <= d_r + 8 * t1_r + 4 * 40'(ry2_r);
                else d_r <= d_r + 8 * t1_r - 8 * t2_r + 4 * 40'(ry2_r);
              end else begin
                if (d_r > 0) d_r <= d_r + 4 * 40'(rx2_r) - 8 * t2_r;
                else d_r <= d_r + 8 * t1_r - 8 * t2_r + 4 * 40'(rx2_r);
              end
            end
          endcase
        end
        pfe_pkg::ST_EL_R2INIT: begin
          if (sub_r == 3'd3) sub_r <= '0;
          else sub_r <= sub_r + 1'b1;
          region_two_r <= 1'b1;
          // squares first, then scale by the squared radii, then the constant term, then the sum
          case (sub_r)
            3'd0: begin
              t1_r <= (2 * exs + 1) * (2 * exs + 1);
              t2_r <= (eys - 1) * (eys - 1);
            end
            3'd1: begin
              t1_r <= 40'(ry2_r) * t1_r;
              t2_r <= 40'(rx2_r) * t2_r;
            end
            3'd2: t2_r <= 4 * t2_r - 4 * (40'(rx2_r) * 40'(ry2_r));
            default: d_r <= t1_r + t2_r;
          endcase
        end
        pfe_pkg::ST_READ: ;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_data = res_r;
  assign out_done_kind = out_kind_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pfe_pkg::ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_data) && $stable(out_done_kind)))
    else $error("result dropped");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfe_pkg::ST_IDLE) |-> !wr_en) else $error("write while idle");
endmodule

FILE: tb/testbench.sv
// Testbench for page_framebuffer_ellipse_engine: drives drawing and read
// commands, predicts every result from a local framebuffer copy. Uses pfe_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic signed [8:0] end_x;
    logic [7:0] radius_x;
    logic [7:0] radius_y;
    logic color;
    logic [9:0] address;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_kind;
  } done_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic signed [8:0] in_pos_x = '0;
  logic signed [8:0] in_pos_y = '0;
  logic signed [8:0] in_end_x = '0;
  logic [7:0] in_radius_x = '0;
  logic [7:0] in_radius_y = '0;
  logic in_color = 1'b0;
  logic [9:0] in_address = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] out_read_data;
  logic [2:0] out_done_kind;

  cmd_t pending_cmds[$];
  done_t expected_done[$];
  logic [7:0] shadow_fb[pfe_pkg::STORE_BYTES];
  int error_count = 0;
  bit hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  page_framebuffer_ellipse_engine u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic void plot_px(int x, int y, bit set);
    int idx;
    if (x < 0 || x >= pfe_pkg::SCREEN_WIDTH || y < 0 || y >= pfe_pkg::SCREEN_HEIGHT) return;
    idx = (y / 8) * pfe_pkg::SCREEN_WIDTH + x;
    if (idx >= pfe_pkg::STORE_BYTES) return;
    if (set) shadow_fb[idx] |= 8'(1 << (y % 8));
    else shadow_fb[idx] &= ~8'(1 << (y % 8));
  endfunction

  function automatic void plot_quad(int cx, int cy, longint x, longint y);
    plot_px(cx + int'(x), cy + int'(y), 1);
    plot_px(cx - int'(x), cy + int'(y), 1);
    plot_px(cx + int'(x), cy - int'(y), 1);
    plot_px(cx - int'(x), cy - int'(y), 1);
  endfunction

  function automatic void trace_ellipse(int cx, int cy, longint rx, longint ry);
    longint x, y, rx2, ry2, d;
    x = 0;
    y = ry;
    rx2 = rx * rx;
    ry2 = ry * ry;
    if (rx == 0 && ry == 0) begin
      plot_px(cx, cy, 1);
      return;
    end
    d = 4 * ry2 - 4 * rx2 * ry + rx2;
    while (2 * ry2 * x <= 2 * rx2 * y) begin
      plot_quad(cx, cy, x, y);
      x++;
      if (d < 0) begin
        d += 4 * (2 * ry2 * x + ry2);
      end else begin
        y--;
        d += 4 * (2 * ry2 * x - 2 * rx2 * y + ry2);
      end
    end
    d = ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1) - 4 * rx2 * ry2;
    while (y >= 0) begin
      plot_quad(cx, cy, x, y);
      y--;
      if (d > 0) begin
        d += 4 * (rx2 - 2 * rx2 * y);
      end else begin
        x++;
        d += 4 * (2 * ry2 * x - 2 * rx2 * y + rx2);
      end
    end
  endfunction

  function automatic done_t apply_cmd(cmd_t c);
    done_t r;
    r.read_data = '0;
    r.done_kind = c.kind;
    case (c.kind)
      pfe_pkg::KIND_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
      pfe_pkg::KIND_PIXEL: plot_px(c.pos_x, c.pos_y, c.color);
      pfe_pkg::KIND_LINE: for (int x = c.pos_x; x <= c.end_x; x++) plot_px(x, c.pos_y, 1);
      pfe_pkg::KIND_ELLIPSE: trace_ellipse(c.pos_x, c.pos_y, c.radius_x, c.radius_y);
      pfe_pkg::KIND_READ:
        if (c.address < pfe_pkg::STORE_BYTES) r.read_data = shadow_fb[c.address];
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: present the next command, hold it while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_done.push_back(apply_cmd(pending_cmds.pop_front()));
        send_gap = pick_gap();
      end
      if (send_gap > 0 && !(in_valid && in_stall)) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_cmds.size() > 0 && !hold_off) begin
        in_valid <= 1'b1;
        in_kind <= pending_cmds[0].kind;
        in_pos_x <= pending_cmds[0].pos_x;
        in_pos_y <= pending_cmds[0].pos_y;
        in_end_x <= pending_cmds[0].end_x;
        in_radius_x <= pending_cmds[0].radius_x;
        in_radius_y <= pending_cmds[0].radius_y;
        in_color <= pending_cmds[0].color;
        in_address <= pending_cmds[0].address;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    done_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_done.size() == 0) begin
          report_mismatch("unexpected result kind", out_done_kind, -1);
        end else begin
          want = expected_done.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_done_kind !== want.done_kind)
            report_mismatch("done_kind", out_done_kind, want.done_kind);
        end
        recv_gap = pick_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic cmd_t make_cmd(int k, int px, int py, int ex, int rx, int ry,
                                    int col, int addr);
    cmd_t c;
    c.kind = 3'(k);
    c.pos_x = 9'(px);
    c.pos_y = 9'(py);
    c.end_x = 9'(ex);
    c.radius_x = 8'(rx);
    c.radius_y = 8'(ry);
    c.color = 1'(col);
    c.address = 10'(addr);
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 35) c.kind = pfe_pkg::KIND_PIXEL;
    else if (r < 50) c.kind = pfe_pkg::KIND_LINE;
    else if (r < 60) c.kind = pfe_pkg::KIND_ELLIPSE;
    else if (r < 95) c.kind = pfe_pkg::KIND_READ;
    else if (r < 97) c.kind = pfe_pkg::KIND_CLEAR;
    else c.kind = 3'($urandom_range(5, 7));
    // Mostly on-screen coordinates and small shapes; some wide values.
    if ($urandom_range(0, 9) < 8) begin
      c.pos_x = 9'($urandom_range(0, 140) - 6);
      c.pos_y = 9'($urandom_range(0, 75) - 6);
      c.end_x = c.pos_x + 9'($urandom_range(0, 40) - 5);
      c.radius_x = 8'($urandom_range(0, 20));
      c.radius_y = 8'($urandom_range(0, 20));
      c.address = 10'($urandom_range(0, pfe_pkg::STORE_BYTES - 1));
    end
    if (c.kind == pfe_pkg::KIND_ELLIPSE && $urandom_range(0, 19) != 0) begin
      c.radius_x = 8'($urandom_range(0, 30));
      c.radius_y = 8'($urandom_range(0, 30));
    end
    return c;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_PIXEL, 127, 63, 0, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_PIXEL, -256, 255, 0, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_PIXEL, 128, 64, 0, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1023));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_LINE, -256, 7, 255, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_LINE, 50, 8, 40, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 5));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_ELLIPSE, 64, 32, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_ELLIPSE, 20, 20, 0, 9, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_ELLIPSE, 64, 32, 0, 255, 255, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_ELLIPSE, 60, 30, 0, 0, 12, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_ELLIPSE, 64, 32, 0, 30, 15, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 256 + 64));
    pending_cmds.push_back(make_cmd(5, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(7, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(pfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 320));
    for (int i = 0; i < 500; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0);
    // Drain fully before sending the rest.
    hold_off = 1;
    wait (expected_done.size() == 0 && !in_valid);
    @(posedge clk);
    hold_off = 0;
    for (int i = 0; i < 500; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0);
    wait (expected_done.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("PASS page_framebuffer_ellipse_engine");
    else
      $display("FAIL page_framebuffer_ellipse_engine");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL page_framebuffer_ellipse_engine");
    $finish;
  end
endmodule
